FILE: hw/rtl/discrete_cdf_position_sampler_core_macros.svh
// Assertion macros for the position sampler core.
// Clocked on clk_i and disabled while rst_ni is low; define NO_ASSERTIONS to drop them.
`ifndef DISCRETE_CDF_POSITION_SAMPLER_CORE_MACROS_SVH
`define DISCRETE_CDF_POSITION_SAMPLER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DCPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DCPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DCPS_ASSERT_IMPL(label, ante, cons, msg)
`define DCPS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/dcps_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the position sampler core.
// No dependencies.
package dcps_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned OutW   = 33;
  localparam int unsigned IdxOutW = 12;
  localparam int unsigned MulW   = 32;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic [PosW-1:0] z;
  } dcps_cell_t;

endpackage

FILE: hw/rtl/dcps_mul.sv
`timescale 1ns / 1ps
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on dcps_pkg.
module dcps_mul import dcps_pkg::*; (
  input  logic                clk_i,
  input  logic [MulW-1:0]     a_i,
  input  logic [MulW-1:0]     b_i,
  output logic [2*MulW-1:0]   p_o
);

  logic [2*MulW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: hw/rtl/dcps_store.sv
`timescale 1ns / 1ps
// Cell table: offsets and cumulative weights, one write and one registered read port.
// Depends on dcps_pkg.
module dcps_store import dcps_pkg::*; #(
  parameter int unsigned Depth = 4096
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(Depth)-1:0]          wr_addr_i,
  input  dcps_cell_t                        wr_cell_i,
  input  logic [32+$clog2(Depth)-1:0]       wr_cum_i,
  input  logic [$clog2(Depth)-1:0]          rd_addr_i,
  output dcps_cell_t                        rd_cell_o,
  output logic [32+$clog2(Depth)-1:0]       rd_cum_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CumW  = 32 + AddrW;

  dcps_cell_t       cell_mem [Depth];
  logic [CumW-1:0]  cum_mem  [Depth];
  dcps_cell_t       rd_cell_q;
  logic [CumW-1:0]  rd_cum_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      cell_mem[wr_addr_i] <= wr_cell_i;
      cum_mem[wr_addr_i]  <= wr_cum_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_cell_q <= cell_mem[rd_addr_i];
    rd_cum_q  <= cum_mem[rd_addr_i];
  end

  assign rd_cell_o = rd_cell_q;
  assign rd_cum_o  = rd_cum_q;

endmodule

FILE: hw/rtl/discrete_cdf_position_sampler_core.sv
`timescale 1ns / 1ps
// Top level of the position sampler: sequencer, table bookkeeping and output register.
// Depends on dcps_pkg, dcps_mul, dcps_store and the assertion macro header.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | req_type, pos_x/y/z, weight, rnd
//   out     | output    | out_valid_o/out_stall_i | status, out_x/y/z, cell_index
//
// Append, clear, unused codes: result registered at accept, moved out in DONE; no new request until then.
// Sample: steps MUL_LO, MUL_HI, TGT, then S search probes, at most floor(log2(entry count)) + 1
//   (13 at 4096 cells), one per cycle through the cumulative table read port; then ADD and DONE.
// Reset clears entry count and total weight; the table needs no clearing pass.
// A stalled result holds in the output register; the block waits in its final step.
`include "discrete_cdf_position_sampler_core_macros.svh"
module discrete_cdf_position_sampler_core import dcps_pkg::*; #(
  parameter int unsigned MAX_CELLS = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic signed [PosW-1:0]     pos_x_i,
  input  logic signed [PosW-1:0]     pos_y_i,
  input  logic signed [PosW-1:0]     pos_z_i,
  input  logic [31:0]                weight_i,
  input  logic [31:0]                rnd_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic signed [OutW-1:0]     out_x_o,
  output logic signed [OutW-1:0]     out_y_o,
  output logic signed [OutW-1:0]     out_z_o,
  output logic [IdxOutW-1:0]         cell_index_o
);

  localparam int unsigned IdxW = $clog2(MAX_CELLS);
  localparam int unsigned CntW = $clog2(MAX_CELLS + 1);
  localparam int unsigned CumW = 32 + IdxW;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_LO, S_MUL_HI, S_TGT, S_SRCH, S_ADD, S_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [CumW-1:0]         total_q, total_d;
  logic [CntW-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic [IdxW-1:0]         mid_q, mid_d;
  logic [CumW-1:0]         target_q, target_d;
  logic [31:0]             plo_q, plo_d;
  logic [31:0]             rnd_q, rnd_d;
  logic signed [PosW-1:0]  ctr_x_q, ctr_x_d, ctr_y_q, ctr_y_d, ctr_z_q, ctr_z_d;
  logic [1:0]              res_status_q, res_status_d;
  logic signed [OutW-1:0]  res_x_q, res_x_d, res_y_q, res_y_d, res_z_q, res_z_d;
  logic [IdxOutW-1:0]      res_idx_q, res_idx_d;
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              out_status_q, out_status_d;
  logic signed [OutW-1:0]  out_x_q, out_x_d, out_y_q, out_y_d, out_z_q, out_z_d;
  logic [IdxOutW-1:0]      out_idx_q, out_idx_d;

  logic                    in_beat;
  logic                    out_free;
  logic                    table_full;
  logic                    wr_en;
  dcps_cell_t              wr_cell;
  logic [CumW-1:0]         wr_cum;
  logic [IdxW-1:0]         rd_addr;
  dcps_cell_t              rd_cell;
  logic [CumW-1:0]         rd_cum;
  logic [MulW-1:0]         mul_b;
  logic [2*MulW-1:0]       mul_p;
  logic                    probe_gt;
  logic [CntW-1:0]         lo_n, hi_n, span_n, fin_n;

  assign in_beat    = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign table_full = (count_q == CntW'(MAX_CELLS));
  assign wr_en      = in_beat && (req_type_i == REQ_APPEND) && !table_full;
  assign wr_cell    = '{x: pos_x_i, y: pos_y_i, z: pos_z_i};
  assign wr_cum     = total_q + CumW'(weight_i);
  assign mul_b      = (state_q == S_MUL_HI) ? MulW'(total_q[CumW-1:32]) : total_q[31:0];

  assign probe_gt = rd_cum > target_q;
  assign lo_n     = probe_gt ? lo_q : CntW'(mid_q) + CntW'(1);
  assign hi_n     = probe_gt ? CntW'(mid_q) : hi_q;
  assign span_n   = hi_n - lo_n;
  assign fin_n    = (lo_n >= count_q) ? count_q - CntW'(1) : lo_n;

  dcps_mul u_mul (
    .clk_i (clk_i),
    .a_i   (rnd_q),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  dcps_store #(
    .Depth (MAX_CELLS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_cell_i (wr_cell),
    .wr_cum_i  (wr_cum),
    .rd_addr_i (rd_addr),
    .rd_cell_o (rd_cell),
    .rd_cum_o  (rd_cum)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    total_d      = total_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    target_d     = target_q;
    plo_d        = plo_q;
    rnd_d        = rnd_q;
    ctr_x_d      = ctr_x_q;
    ctr_y_d      = ctr_y_q;
    ctr_z_d      = ctr_z_q;
    res_status_d = res_status_q;
    res_x_d      = res_x_q;
    res_y_d      = res_y_q;
    res_z_d      = res_z_q;
    res_idx_d    = res_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_z_d      = out_z_q;
    out_idx_d    = out_idx_q;
    rd_addr      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          res_status_d = STATUS_OK;
          res_x_d      = '0;
          res_y_d      = '0;
          res_z_d      = '0;
          res_idx_d    = '0;
          rnd_d        = rnd_i;
          ctr_x_d      = pos_x_i;
          ctr_y_d      = pos_y_i;
          ctr_z_d      = pos_z_i;
          state_d      = S_DONE;
          case (req_type_i)
            REQ_APPEND: begin
              if (table_full) begin
                res_status_d = STATUS_FULL;
              end else begin
                count_d = count_q + CntW'(1);
                total_d = wr_cum;
              end
            end
            REQ_SAMPLE: begin
              if (count_q == '0 || total_q == '0) begin
                res_status_d = STATUS_EMPTY;
              end else begin
                state_d = S_MUL_LO;
              end
            end
            REQ_CLEAR: begin
              count_d = '0;
              total_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL_LO: begin
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        plo_d   = mul_p[63:32];
        state_d = S_TGT;
      end
      S_TGT: begin
        target_d = mul_p[CumW-1:0] + CumW'(plo_q);
        lo_d     = '0;
        hi_d     = count_q;
        mid_d    = IdxW'(count_q >> 1);
        rd_addr  = IdxW'(count_q >> 1);
        state_d  = S_SRCH;
      end
      S_SRCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d   = IdxW'(lo_n + (span_n >> 1));
          rd_addr = IdxW'(lo_n + (span_n >> 1));
        end else begin
          lo_d    = fin_n;
          rd_addr = fin_n[IdxW-1:0];
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        res_x_d   = OutW'(ctr_x_q) + OutW'($signed(rd_cell.x));
        res_y_d   = OutW'(ctr_y_q) + OutW'($signed(rd_cell.y));
        res_z_d   = OutW'(ctr_z_q) + OutW'($signed(rd_cell.z));
        res_idx_d = IdxOutW'(lo_q);
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_x_d      = res_x_q;
          out_y_d      = res_y_q;
          out_z_d      = res_z_q;
          out_idx_d    = res_idx_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      total_q      <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      mid_q        <= '0;
      target_q     <= '0;
      plo_q        <= '0;
      rnd_q        <= '0;
      ctr_x_q      <= '0;
      ctr_y_q      <= '0;
      ctr_z_q      <= '0;
      res_status_q <= STATUS_OK;
      res_x_q      <= '0;
      res_y_q      <= '0;
      res_z_q      <= '0;
      res_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OK;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_z_q      <= '0;
      out_idx_q    <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      total_q      <= total_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      mid_q        <= mid_d;
      target_q     <= target_d;
      plo_q        <= plo_d;
      rnd_q        <= rnd_d;
      ctr_x_q      <= ctr_x_d;
      ctr_y_q      <= ctr_y_d;
      ctr_z_q      <= ctr_z_d;
      res_status_q <= res_status_d;
      res_x_q      <= res_x_d;
      res_y_q      <= res_y_d;
      res_z_q      <= res_z_d;
      res_idx_q    <= res_idx_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_x_q      <= out_x_d;
      out_y_q      <= out_y_d;
      out_z_q      <= out_z_d;
      out_idx_q    <= out_idx_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_z_o      = out_z_q;
  assign cell_index_o = out_idx_q;

  `DCPS_ASSERT_NEXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o, "no stall after beat")
  `DCPS_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(MAX_CELLS), "entry count overflow")
  `DCPS_ASSERT_IMPL(a_probe_in_table, state_q == S_SRCH, CntW'(mid_q) < count_q, "probe past end")
  `DCPS_ASSERT_IMPL(a_sample_has_weight, state_q == S_MUL_LO, total_q != '0, "zero total sampled")
  `DCPS_ASSERT_NEXT(a_result_loaded, state_q == S_DONE && out_free, out_valid_o, "result lost")

endmodule
